@@ hw/rtl/altm_pkg.sv @@
// Shared types, widths and fixed-point constants for the ADC linearizer
// with trimmed mean. No dependencies; every other file imports this package.
`default_nettype none

package altm_pkg;

	// Group size and converter resolution.
	localparam int SAMPLES   = 10;
	localparam int ADC_BITS  = 12;
	localparam int TRIM_DIV  = SAMPLES - 2;
	localparam int CNT_W     = $clog2(SAMPLES);

	// Field widths.
	localparam int CODE_W    = 12;
	localparam int AVG_W     = 13;
	localparam int OFF_W     = 10;
	localparam int SUM_W     = 16;
	localparam int KEPT_W    = 17;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_CAL    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(1);

	// Code handling and thresholds.
	localparam logic [CODE_W-1:0] CODE_MASK  = CODE_W'((1 << ADC_BITS) - 1);
	localparam logic [CODE_W-1:0] QUAD_KNEE  = CODE_W'(2599);
	localparam logic [CODE_W-1:0] BLEND_HIGH = CODE_W'(200);
	localparam logic [CODE_W-1:0] BLEND_LOW  = CODE_W'(100);
	localparam logic [CODE_W-1:0] MV_MAX     = CODE_W'(4095);

	// Shared multiplier geometry.
	localparam int MUL_A_W = 29;
	localparam int MUL_B_W = 26;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Curve coefficients with 16 fraction bits (quadratic term with 32).
	localparam logic signed [MUL_B_W-1:0] K_QUAD2 = 26'sd626027;
	localparam logic signed [MUL_B_W-1:0] K_QUAD1 = 26'sd98967;
	localparam logic signed [MUL_B_W-1:0] K_LIN1  = 26'sd54913;
	localparam logic signed [MUL_B_W-1:0] K_LOW1  = 26'sd16005;
	localparam logic signed [31:0]        K_QUAD0 = -32'sd44620710;
	localparam logic signed [31:0]        K_LIN0  = 32'sd5346895;

	// Blend scaling: floor(S / (100 * 2^16)) = floor((S >> 18) / 25),
	// and x / 25 = (x * 167773) >> 22 for every 17-bit x.
	localparam int BLEND_SHIFT = 18;
	localparam int RECIP_X_W   = 17;
	localparam int RECIP_SHIFT = 22;
	localparam logic signed [MUL_B_W-1:0] RECIP25 = 26'sd167773;

	// Final division by the trimmed group size as a reciprocal multiply.
	localparam int DIV_SHIFT = 24;
	localparam logic signed [MUL_B_W-1:0] DIV_RECIP =
		MUL_B_W'((2 ** DIV_SHIFT + TRIM_DIV - 1) / TRIM_DIV);

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_SQ,
		OP_QUAD,
		OP_LINE,
		OP_LOWL,
		OP_BLHI,
		OP_BLLO,
		OP_RECIP,
		OP_DIV
	} altm_op_t;

	typedef struct packed {
		logic     load;
		logic     accum;
		altm_op_t op;
	} altm_cmd_t;

	typedef struct packed {
		logic cal;
		logic in_quad;
		logic in_low;
		logic blend;
		logic low;
		logic last;
		logic out_blocked;
	} altm_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/altm_ctrl.sv @@
// Sequencer for the ADC linearizer: steps the shared multiplier through the
// curve segments of each item. Depends on altm_pkg.
`default_nettype none

module altm_ctrl import altm_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         sample_valid,
	output logic              sample_stall,
	input  wire altm_status_t status,
	output altm_cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_QUAD,
		ST_LINE,
		ST_LOWL,
		ST_BLHI,
		ST_BLLO,
		ST_RECIP,
		ST_ACCUM,
		ST_DIV
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   accept;

	assign accept       = sample_valid && !stall_q;
	assign sample_stall = stall_q;

	// State and the registered stall toward the input side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						stall_q <= 1'b1;
						if (!status.cal) begin
							state_q <= ST_ACCUM;
						end else if (status.in_low) begin
							state_q <= ST_LOWL;
						end else if (status.in_quad) begin
							state_q <= ST_SQ;
						end else begin
							state_q <= ST_LINE;
						end
					end
				end
				ST_SQ:    state_q <= ST_QUAD;
				ST_QUAD:  state_q <= ST_LINE;
				ST_LINE:  state_q <= status.blend ? ST_LOWL : ST_ACCUM;
				ST_LOWL:  state_q <= status.low ? ST_ACCUM : ST_BLHI;
				ST_BLHI:  state_q <= ST_BLLO;
				ST_BLLO:  state_q <= ST_RECIP;
				ST_RECIP: state_q <= ST_ACCUM;
				ST_ACCUM: begin
					if (status.last) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (!status.out_blocked) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	// Command decode for the datapath.
	always_comb begin
		cmd.load  = accept;
		cmd.accum = (state_q == ST_ACCUM);
		unique case (state_q)
			ST_SQ:    cmd.op = OP_SQ;
			ST_QUAD:  cmd.op = OP_QUAD;
			ST_LINE:  cmd.op = OP_LINE;
			ST_LOWL:  cmd.op = OP_LOWL;
			ST_BLHI:  cmd.op = OP_BLHI;
			ST_BLLO:  cmd.op = OP_BLLO;
			ST_RECIP: cmd.op = OP_RECIP;
			ST_DIV:   cmd.op = status.out_blocked ? OP_NONE : OP_DIV;
			default:  cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/altm_datapath.sv @@
// Datapath of the ADC linearizer: configuration registers, shared multiplier,
// curve registers, group statistics and the result register. Uses altm_pkg.
`default_nettype none

module altm_datapath import altm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [OFF_W-1:0]     cfg_data,
	input  wire logic [CODE_W-1:0]    code_high_atten,
	input  wire logic [CODE_W-1:0]    code_low_atten,
	input  wire altm_cmd_t            cmd,
	output altm_status_t              status,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [AVG_W-1:0]          average
);

	logic                      cal_q;
	logic [OFF_W-1:0]          offset_q;
	logic [CODE_W-1:0]         hi_q;
	logic [CODE_W-1:0]         lo_q;
	logic [2*CODE_W-1:0]       sq_q;
	logic [27:0]               quad_q;
	logic signed [31:0]        v_q;
	logic signed [MUL_A_W-1:0] v0_q;
	logic signed [35:0]        bl_q;
	logic [AVG_W-1:0]          r_q;
	logic [CNT_W-1:0]          count_q;
	logic [SUM_W-1:0]          sum_q;
	logic [CODE_W-1:0]         min_q;
	logic [CODE_W-1:0]         max_q;
	logic                      result_valid_q;
	logic [AVG_W-1:0]          average_q;

	logic [CODE_W-1:0]         hi_in;
	logic                      is_quad;
	logic                      last;
	logic signed [25:0]        off_q16;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W:0]    quad_term;
	logic signed [PROD_W:0]    line_sum;
	logic signed [PROD_W:0]    lowl_sum;
	logic [RECIP_X_W-1:0]      recip_x;
	logic [KEPT_W-1:0]         kept;
	logic [KEPT_W-1:0]         kept_fin;
	logic [CODE_W-1:0]         samp;

	// Whole millivolts from a value with 16 fraction bits, clamped to range.
	function automatic logic [CODE_W-1:0] sat_q16(input logic signed [31:0] v);
		logic [CODE_W-1:0] res;
		if (v[31]) begin
			res = '0;
		end else if (v[31:16] > 16'(MV_MAX)) begin
			res = MV_MAX;
		end else begin
			res = v[16+CODE_W-1:16];
		end
		return res;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q    <= 1'b0;
			offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL:    cal_q    <= cfg_data[0];
				REG_OFFSET: offset_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Segment flags for the controller.
	assign hi_in   = code_high_atten & CODE_MASK;
	assign is_quad = hi_q > QUAD_KNEE;
	assign last    = (count_q == CNT_W'(SAMPLES - 1));

	assign status.cal         = cal_q;
	assign status.in_quad     = hi_in > QUAD_KNEE;
	assign status.in_low      = hi_in < BLEND_LOW;
	assign status.blend       = hi_q < BLEND_HIGH;
	assign status.low         = hi_q < BLEND_LOW;
	assign status.last        = last;
	assign status.out_blocked = result_valid_q && result_stall;

	assign off_q16 = $signed({offset_q, 16'b0});

	// Blend sum scaled down for the divide by 25; negative sums give zero.
	assign recip_x = bl_q[35] ? '0 : bl_q[BLEND_SHIFT+RECIP_X_W-1:BLEND_SHIFT];

	// Trimmed sum, doubled in calibrated mode.
	assign kept     = KEPT_W'(sum_q) - KEPT_W'(min_q) - KEPT_W'(max_q);
	assign kept_fin = cal_q ? KEPT_W'(kept << 1) : kept;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ: begin
				mul_a = MUL_A_W'(hi_q);
				mul_b = MUL_B_W'(hi_q);
			end
			OP_QUAD: begin
				mul_a = MUL_A_W'(sq_q);
				mul_b = K_QUAD2;
			end
			OP_LINE: begin
				mul_a = MUL_A_W'(hi_q);
				mul_b = is_quad ? K_QUAD1 : K_LIN1;
			end
			OP_LOWL: begin
				mul_a = MUL_A_W'(lo_q);
				mul_b = K_LOW1;
			end
			OP_BLHI: begin
				mul_a = $signed(v_q[MUL_A_W-1:0]);
				mul_b = MUL_B_W'(hi_q - BLEND_LOW);
			end
			OP_BLLO: begin
				mul_a = v0_q;
				mul_b = MUL_B_W'(BLEND_HIGH - hi_q);
			end
			OP_RECIP: begin
				mul_a = MUL_A_W'(recip_x);
				mul_b = RECIP25;
			end
			OP_DIV: begin
				mul_a = MUL_A_W'(kept_fin);
				mul_b = DIV_RECIP;
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	// Adders behind the multiplier for the line and low-range segments.
	assign quad_term = is_quad ? (PROD_W+1)'($signed({1'b0, quad_q})) : (PROD_W+1)'(0);
	assign line_sum  = (PROD_W+1)'(prod) + (PROD_W+1)'(is_quad ? K_QUAD0 : K_LIN0)
		+ (PROD_W+1)'(off_q16) - quad_term;
	assign lowl_sum  = (PROD_W+1)'(prod) + (PROD_W+1)'(off_q16);

	// Pick the sample for the group statistics.
	always_comb begin
		if (!cal_q) begin
			samp = hi_q;
		end else if (status.low) begin
			samp = sat_q16(32'(v0_q));
		end else if (status.blend) begin
			samp = (r_q > AVG_W'(MV_MAX)) ? MV_MAX : r_q[CODE_W-1:0];
		end else begin
			samp = sat_q16(v_q);
		end
	end

	// Item and curve registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hi_q <= hi_in;
			lo_q <= code_low_atten & CODE_MASK;
		end
		case (cmd.op)
			OP_SQ:    sq_q   <= prod[2*CODE_W-1:0];
			OP_QUAD:  quad_q <= prod[43:16];
			OP_LINE:  v_q    <= line_sum[31:0];
			OP_LOWL:  v0_q   <= lowl_sum[MUL_A_W-1:0];
			OP_BLHI:  bl_q   <= prod[35:0];
			OP_BLLO:  bl_q   <= bl_q + $signed(prod[35:0]);
			OP_RECIP: r_q    <= prod[RECIP_SHIFT+AVG_W-1:RECIP_SHIFT];
			default:  ;
		endcase
	end

	// Group minimum and maximum; the first sample of a group writes both.
	always_ff @(posedge clk) begin
		if (cmd.accum) begin
			if (count_q == '0) begin
				min_q <= samp;
				max_q <= samp;
			end else begin
				if (samp < min_q) begin
					min_q <= samp;
				end
				if (samp > max_q) begin
					max_q <= samp;
				end
			end
		end
	end

	// Sample counter and running sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (cmd.accum) begin
			if (count_q == '0) begin
				sum_q <= SUM_W'(samp);
			end else begin
				sum_q <= sum_q + SUM_W'(samp);
			end
			count_q <= last ? '0 : count_q + CNT_W'(1);
		end
	end

	// Output register; a new result may load in the cycle the old one leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.op == OP_DIV) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIV) begin
			average_q <= prod[DIV_SHIFT+AVG_W-1:DIV_SHIFT];
		end
	end

	assign result_valid = result_valid_q;
	assign average      = average_q;

endmodule

`default_nettype wire

@@ hw/rtl/adc_linearize_trimmed_mean.sv @@
// ADC linearizer with trimmed mean. In raw mode an item is only accumulated; in
// calibrated mode it first steps through the multiplies of its curve segment
// (linear, low range, quadratic or blend zone) on the single shared multiplier.
// No new item is taken before the last is done. The last item of a group adds a
// step that loads the average into the output register, held while a result stalls.
// Reset is asynchronous, active low: control, configuration, count and sum cleared.
`default_nettype none

module adc_linearize_trimmed_mean import altm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [OFF_W-1:0]     cfg_data,
	input  wire logic                 sample_valid,
	output logic                      sample_stall,
	input  wire logic [CODE_W-1:0]    code_high_atten,
	input  wire logic [CODE_W-1:0]    code_low_atten,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [AVG_W-1:0]          average
);

	altm_cmd_t    cmd;
	altm_status_t status;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	altm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	altm_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.code_high_atten (code_high_atten),
		.code_low_atten  (code_low_atten),
		.cmd             (cmd),
		.status          (status),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.average         (average)
	);

endmodule

`default_nettype wire

@@ hw/rtl/altm_checker.sv @@
// Port-level checks for the ADC linearizer, bound to the top level.
// Depends on altm_pkg for port widths.
`default_nettype none

module altm_checker import altm_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             sample_valid,
	input wire logic             sample_stall,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire logic [AVG_W-1:0] average
);

	// A stalled result item holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(average))
	else $error("stalled result item changed");

	// An accepted item keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
	else $error("block idle right after accepting an item");

	// With no item offered, an idle block stays idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!sample_valid && !sample_stall |=> !sample_stall)
	else $error("block went busy without an item");

	// A new result appears only at the end of an item's processing.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall))
	else $error("result appeared while the block was idle");

endmodule

bind adc_linearize_trimmed_mean altm_checker u_altm_checker (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for adc_linearize_trimmed_mean: drives code pairs
// and register writes, predicts every group average and compares it.
// Depends on altm_pkg for widths and register indexes, and on the block itself.

module tb_top;
	import altm_pkg::*;

	// Curve coefficients with 16 fraction bits; the square term has 32.
	localparam longint CURVE_SQ       = 626027;
	localparam longint CURVE_SLOPE_HI = 98967;
	localparam longint CURVE_ICPT_HI  = -44620710;
	localparam longint LINE_SLOPE     = 54913;
	localparam longint LINE_ICPT      = 5346895;
	localparam longint LOW_SLOPE      = 16005;
	localparam longint ONE_MV_Q       = 65536;
	localparam longint KNEE_CODE      = 2599;
	localparam longint BLEND_TOP      = 200;
	localparam longint BLEND_BOT      = 100;
	localparam longint BLEND_DIV      = 100;
	localparam longint SAT_MV         = 4095;

	localparam int GROUP_LEN     = 10;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 300;
	localparam int RAND_PHASES   = 8;

	typedef struct packed {
		logic [CODE_W-1:0] hi;
		logic [CODE_W-1:0] lo;
	} code_pair_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid       = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index       = REG_CAL;
	logic [OFF_W-1:0]     cfg_data        = '0;
	logic                 sample_valid    = 1'b0;
	logic                 sample_stall;
	logic [CODE_W-1:0]    code_high_atten = '0;
	logic [CODE_W-1:0]    code_low_atten  = '0;
	logic                 result_valid;
	logic                 result_stall    = 1'b0;
	logic [AVG_W-1:0]     average;

	// Items waiting to be offered and averages waiting to arrive.
	code_pair_t       pair_q[$];
	logic [AVG_W-1:0] avg_due[$];

	// Register copies and group state of the predictor.
	logic                    cal_mode = 1'b0;
	logic signed [OFF_W-1:0] off_mv   = '0;
	int                      grp_count = 0;
	logic [15:0]             grp_sum   = '0;
	logic [CODE_W-1:0]       grp_min   = '0;
	logic [CODE_W-1:0]       grp_max   = '0;

	// Idle control for both sides.
	logic send_idle_on = 1'b1;
	logic rcv_idle_on  = 1'b1;
	int   send_gap     = 0;
	int   rcv_gap      = 0;
	logic hold_go      = 1'b0;
	int   hold_left    = 0;

	int   mismatch_count = 0;
	logic offering;
	logic stall_next;
	logic [AVG_W-1:0] avg_want;

	adc_linearize_trimmed_mean i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.code_high_atten (code_high_atten),
		.code_low_atten  (code_low_atten),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.average         (average)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Converts one code pair to millivolts plus offset, saturated to 0..4095.
	function automatic logic [CODE_W-1:0] millivolts(input logic [CODE_W-1:0] hi,
			input logic [CODE_W-1:0] lo, input logic signed [OFF_W-1:0] off);
		longint h, l, off_q, v, v0, sq;
		logic [CODE_W-1:0] mv;
		h = longint'(hi & CODE_MASK);
		l = longint'(lo & CODE_MASK);
		off_q = longint'(off) * ONE_MV_Q;
		if (h > KNEE_CODE) begin
			sq = (h * h * CURVE_SQ) >>> 16;
			v = -sq + CURVE_SLOPE_HI * h + CURVE_ICPT_HI + off_q;
		end else begin
			v = LINE_SLOPE * h + LINE_ICPT + off_q;
		end
		// Near zero the low-attenuation line takes over, blended in between.
		if (h < BLEND_TOP) begin
			v0 = LOW_SLOPE * l + off_q;
			if (h >= BLEND_BOT)
				v = (v * (h - BLEND_BOT) + v0 * (BLEND_TOP - h)) / BLEND_DIV;
			else
				v = v0;
		end
		if (v < 0) begin
			mv = '0;
		end else begin
			v = v / ONE_MV_Q;
			mv = (v > SAT_MV) ? CODE_W'(SAT_MV) : v[CODE_W-1:0];
		end
		return mv;
	endfunction

	// Adds one accepted item to the group and queues the average at its end.
	task automatic accumulate_sample(input code_pair_t pair);
		logic [CODE_W-1:0] s;
		logic [31:0] kept;
		s = cal_mode ? millivolts(pair.hi, pair.lo, off_mv) : (pair.hi & CODE_MASK);
		if (grp_count == 0) begin
			grp_min = s;
			grp_max = s;
			grp_sum = '0;
		end
		if (s > grp_max)
			grp_max = s;
		if (s < grp_min)
			grp_min = s;
		grp_sum = grp_sum + 16'(s);
		grp_count++;
		if (grp_count == GROUP_LEN) begin
			kept = 32'(grp_sum) - 32'(grp_min) - 32'(grp_max);
			if (cal_mode)
				kept = kept * 2;
			avg_due.push_back(AVG_W'(kept / (GROUP_LEN - 2)));
			grp_count = 0;
			grp_sum = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	// Mostly back to back, sometimes a few cycles, now and then a long gap.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Codes weighted toward the low-attenuation and blend zones, with zone boundaries mixed in.
	function automatic logic [CODE_W-1:0] pick_code();
		int r;
		logic [CODE_W-1:0] code;
		r = $urandom_range(0, 9);
		case (r)
			0: code = CODE_W'($urandom_range(0, 99));
			1, 2: code = CODE_W'($urandom_range(100, 199));
			3, 4, 5: code = CODE_W'($urandom_range(200, 2599));
			6, 7, 8: code = CODE_W'($urandom_range(2600, 4095));
			default: begin
				case ($urandom_range(0, 7))
					0: code = 12'd0;
					1: code = 12'd99;
					2: code = 12'd100;
					3: code = 12'd199;
					4: code = 12'd200;
					5: code = 12'd2599;
					6: code = 12'd2600;
					default: code = 12'd4095;
				endcase
			end
		endcase
		return code;
	endfunction

	function automatic logic [OFF_W-1:0] pick_offset();
		logic [OFF_W-1:0] off;
		case ($urandom_range(0, 3))
			0: off = 10'h200;
			1: off = 10'h1FF;
			2: off = '0;
			default: off = OFF_W'($urandom);
		endcase
		return off;
	endfunction

	// Sender: offers queued items and predicts each one as it is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			offering = sample_valid;
			if (sample_valid && !sample_stall) begin
				accumulate_sample(pair_q[0]);
				pair_q.delete(0);
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pair_q.size() > 0) begin
					code_high_atten <= pair_q[0].hi;
					code_low_atten <= pair_q[0].lo;
					offering = 1'b1;
					send_gap = send_idle_on ? pick_gap() : 0;
				end
			end
			sample_valid <= offering;
		end
	end

	// Receiver: checks each accepted average against the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (avg_due.size() == 0) begin
					report_mismatch("average with nothing expected", average, 0);
				end else begin
					avg_want = avg_due.pop_front();
					if (average !== avg_want)
						report_mismatch("average", average, avg_want);
				end
			end
			if (hold_left > 0) begin
				stall_next = 1'b1;
			end else if (rcv_gap > 0) begin
				rcv_gap--;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
				rcv_gap = rcv_idle_on ? pick_gap() : 0;
			end
			result_stall <= stall_next;
		end
	end

	// Long receiver hold-off, counted here in clock cycles.
	always @(posedge clk) begin
		if (hold_go) begin
			hold_left <= LONG_HOLD;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFF_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_CAL)
			cal_mode = data[0];
		else if (idx == REG_OFFSET)
			off_mv = data;
	endtask

	// The unused upper bits of the mode write are random to show they are ignored.
	task automatic set_config(input logic cal, input logic [OFF_W-1:0] off);
		write_reg(REG_CAL, {9'($urandom), cal});
		write_reg(REG_OFFSET, off);
	endtask

	task automatic queue_pair(input int hi, input int lo);
		pair_q.push_back('{hi: CODE_W'(hi), lo: CODE_W'(lo)});
	endtask

	task automatic queue_random(input int n);
		@(negedge clk);
		repeat (n) queue_pair(pick_code(), $urandom_range(0, 4095));
	endtask

	// Waits until every item is taken and every average has arrived, then
	// lets the block finish an item that produces no average.
	task automatic wait_quiet();
		while (pair_q.size() != 0 || sample_valid || avg_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int n;
		int split;
		logic cal;
		logic [OFF_W-1:0] off;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Raw mode: extremes and alternating bit patterns of both codes.
		set_config(1'b0, '0);
		@(negedge clk);
		queue_pair(0, 4095);
		queue_pair(4095, 0);
		queue_pair('hAAA, 'h555);
		queue_pair('h555, 'hAAA);
		queue_pair(1, 4095);
		queue_pair(2048, 0);
		queue_pair(4094, 1);
		queue_pair(0, 0);
		queue_pair(4095, 4095);
		queue_pair(100, 2048);
		wait_quiet();

		// Calibrated mode across every zone boundary with the largest offset.
		set_config(1'b1, 10'h1FF);
		@(negedge clk);
		queue_pair(0, 4095);
		queue_pair(99, 0);
		queue_pair(100, 4095);
		queue_pair(150, 2000);
		queue_pair(199, 4095);
		queue_pair(200, 0);
		queue_pair(2599, 4095);
		queue_pair(2600, 0);
		queue_pair(4095, 4095);
		queue_pair(3000, 1234);
		wait_quiet();

		// Most negative offset drives low samples below zero; the group is
		// left half done so the next phase changes the mode within it.
		set_config(1'b1, 10'h200);
		@(negedge clk);
		queue_pair(0, 0);
		queue_pair(50, 100);
		queue_pair(150, 0);
		queue_pair(199, 10);
		queue_pair(2000, 0);
		wait_quiet();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					cal = 1'b0;
					off = pick_offset();
				end
				1: begin
					cal = 1'b1;
					off = pick_offset();
				end
				2: begin
					cal = 1'b1;
					off = 10'h200;
				end
				3: begin
					cal = 1'b1;
					off = 10'h1FF;
				end
				default: begin
					cal = 1'($urandom_range(0, 1));
					off = pick_offset();
				end
			endcase
			set_config(cal, off);
			@(negedge clk);
			send_idle_on = !(ph == 1 || ph == 3);
			rcv_idle_on = (ph != 1);
			n = $urandom_range(55, 80);
			split = (ph == 3) ? n : $urandom_range(10, n - 10);
			queue_random(split);
			// Receiver holds off while the sender keeps offering items; the
			// request is high across exactly one rising edge.
			if (ph == 3) begin
				hold_go = 1'b1;
				@(negedge clk);
				hold_go = 1'b0;
			end
			if (ph != 3 && $urandom_range(0, 1))
				wait_quiet();
			queue_random(n - split);
			wait_quiet();
		end

		if (avg_due.size() != 0)
			report_mismatch("averages never delivered", avg_due.size(), 0);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
